// ===== rtl/rvdec_pkg.sv =====
`default_nettype none

package rvdec_pkg;

    localparam int unsigned InstrWidth = 32;

    // Major opcodes, bits 6:0.
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] FUNCT7_ALT = 7'h20;

    // SYSTEM codes held in bits 31:20.
    localparam logic [11:0] SYS_ENV_CALL    = 12'h000;
    localparam logic [11:0] SYS_ENV_BREAK   = 12'h001;
    localparam logic [11:0] SYS_MACHINE_RET = 12'h302;

    // Instruction formats.
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_S = 3'd2;
    localparam logic [2:0] FMT_B = 3'd3;
    localparam logic [2:0] FMT_U = 3'd4;
    localparam logic [2:0] FMT_J = 3'd5;

    // Instruction classes.
    localparam logic [5:0] CLS_ADD     = 6'd0;
    localparam logic [5:0] CLS_SUB     = 6'd1;
    localparam logic [5:0] CLS_SLL     = 6'd2;
    localparam logic [5:0] CLS_SLT     = 6'd3;
    localparam logic [5:0] CLS_SLTU    = 6'd4;
    localparam logic [5:0] CLS_XOR     = 6'd5;
    localparam logic [5:0] CLS_SRL     = 6'd6;
    localparam logic [5:0] CLS_SRA     = 6'd7;
    localparam logic [5:0] CLS_OR      = 6'd8;
    localparam logic [5:0] CLS_AND     = 6'd9;
    localparam logic [5:0] CLS_ADDI    = 6'd10;
    localparam logic [5:0] CLS_SLTI    = 6'd11;
    localparam logic [5:0] CLS_SLTIU   = 6'd12;
    localparam logic [5:0] CLS_XORI    = 6'd13;
    localparam logic [5:0] CLS_ORI     = 6'd14;
    localparam logic [5:0] CLS_ANDI    = 6'd15;
    localparam logic [5:0] CLS_SLLI    = 6'd16;
    localparam logic [5:0] CLS_SRLI    = 6'd17;
    localparam logic [5:0] CLS_SRAI    = 6'd18;
    localparam logic [5:0] CLS_LB      = 6'd19;
    localparam logic [5:0] CLS_LH      = 6'd20;
    localparam logic [5:0] CLS_LW      = 6'd21;
    localparam logic [5:0] CLS_LBU     = 6'd22;
    localparam logic [5:0] CLS_LHU     = 6'd23;
    localparam logic [5:0] CLS_SB      = 6'd24;
    localparam logic [5:0] CLS_SH      = 6'd25;
    localparam logic [5:0] CLS_SW      = 6'd26;
    localparam logic [5:0] CLS_BEQ     = 6'd27;
    localparam logic [5:0] CLS_BNE     = 6'd28;
    localparam logic [5:0] CLS_BLT     = 6'd29;
    localparam logic [5:0] CLS_BGE     = 6'd30;
    localparam logic [5:0] CLS_BLTU    = 6'd31;
    localparam logic [5:0] CLS_BGEU    = 6'd32;
    localparam logic [5:0] CLS_JAL     = 6'd33;
    localparam logic [5:0] CLS_JALR    = 6'd34;
    localparam logic [5:0] CLS_LUI     = 6'd35;
    localparam logic [5:0] CLS_AUIPC   = 6'd36;
    localparam logic [5:0] CLS_ECALL   = 6'd37;
    localparam logic [5:0] CLS_EBREAK  = 6'd38;
    localparam logic [5:0] CLS_MRET    = 6'd39;
    localparam logic [5:0] CLS_UNKNOWN = 6'd40;

    // ALU operations.
    localparam logic [3:0] ALU_ADD      = 4'd0;
    localparam logic [3:0] ALU_SUB      = 4'd1;
    localparam logic [3:0] ALU_SLL      = 4'd2;
    localparam logic [3:0] ALU_SLT      = 4'd3;
    localparam logic [3:0] ALU_SLT_UNS  = 4'd4;
    localparam logic [3:0] ALU_XOR      = 4'd5;
    localparam logic [3:0] ALU_SRL      = 4'd6;
    localparam logic [3:0] ALU_SRA      = 4'd7;
    localparam logic [3:0] ALU_OR       = 4'd8;
    localparam logic [3:0] ALU_AND      = 4'd9;
    localparam logic [3:0] ALU_PASS_IMM = 4'd10;
    localparam logic [3:0] ALU_PC_PLUS  = 4'd11;

    // Execution units.
    localparam logic [3:0] UNIT_ALU_R  = 4'd0;
    localparam logic [3:0] UNIT_ALU_I  = 4'd1;
    localparam logic [3:0] UNIT_LOAD   = 4'd2;
    localparam logic [3:0] UNIT_STORE  = 4'd3;
    localparam logic [3:0] UNIT_BRANCH = 4'd4;
    localparam logic [3:0] UNIT_JAL    = 4'd5;
    localparam logic [3:0] UNIT_JALR   = 4'd6;
    localparam logic [3:0] UNIT_SYSTEM = 4'd7;
    localparam logic [3:0] UNIT_OTHER  = 4'd8;

    // Members run from the top bit down, so dest_reg sits in the lowest bits.
    typedef struct packed {
        logic               reads_src2;
        logic               reads_src1;
        logic               writes_dest;
        logic [3:0]         unit_kind;
        logic [3:0]         alu_code;
        logic [5:0]         instr_class;
        logic [2:0]         format_kind;
        logic signed [31:0] immediate;
        logic [2:0]         func3_field;
        logic [4:0]         src2_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         dest_reg;
    } decode_result_t;

    localparam int unsigned ResultWidth = $bits(decode_result_t);
    localparam int unsigned ResultBytes = (ResultWidth + 7) / 8;
    localparam int unsigned ResultPad   = ResultBytes * 8 - ResultWidth;

endpackage

`default_nettype wire

// ===== rtl/rvdec_in_reg.sv =====
`default_nettype none

module rvdec_in_reg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rvdec_pkg::InstrWidth-1:0]  s_word,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [rvdec_pkg::InstrWidth-1:0]       m_word
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [rvdec_pkg::InstrWidth-1:0] word_reg;

    // The stage takes a new word whenever it is empty or its word leaves now.
    assign s_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg <= s_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

`default_nettype wire

// ===== rtl/rvdec_decode.sv =====
`default_nettype none

module rvdec_decode (
    input  wire logic [rvdec_pkg::InstrWidth-1:0] instruction,
    output rvdec_pkg::decode_result_t            result
);

    logic [6:0] opc;
    logic [2:0] f3;
    logic       alt;
    logic [2:0] fmt;
    logic [5:0] cls;
    logic [3:0] alu;
    logic [3:0] unit;
    logic [3:0] alu_f3;
    logic [31:0] imm;

    assign opc = instruction[6:0];
    assign f3  = instruction[14:12];
    assign alt = (instruction[31:25] == rvdec_pkg::FUNCT7_ALT);

    // ALU operation that funct3 selects for OP and OP-IMM.
    always_comb begin
        case (f3)
            3'd0:    alu_f3 = rvdec_pkg::ALU_ADD;
            3'd1:    alu_f3 = rvdec_pkg::ALU_SLL;
            3'd2:    alu_f3 = rvdec_pkg::ALU_SLT;
            3'd3:    alu_f3 = rvdec_pkg::ALU_SLT_UNS;
            3'd4:    alu_f3 = rvdec_pkg::ALU_XOR;
            3'd5:    alu_f3 = rvdec_pkg::ALU_SRL;
            3'd6:    alu_f3 = rvdec_pkg::ALU_OR;
            default: alu_f3 = rvdec_pkg::ALU_AND;
        endcase
    end

    always_comb begin
        fmt  = rvdec_pkg::FMT_R;
        cls  = rvdec_pkg::CLS_UNKNOWN;
        alu  = rvdec_pkg::ALU_ADD;
        unit = rvdec_pkg::UNIT_OTHER;
        case (opc)
            rvdec_pkg::OPC_OP: begin
                unit = rvdec_pkg::UNIT_ALU_R;
                alu  = alu_f3;
                case (f3)
                    3'd0:    cls = rvdec_pkg::CLS_ADD;
                    3'd1:    cls = rvdec_pkg::CLS_SLL;
                    3'd2:    cls = rvdec_pkg::CLS_SLT;
                    3'd3:    cls = rvdec_pkg::CLS_SLTU;
                    3'd4:    cls = rvdec_pkg::CLS_XOR;
                    3'd5:    cls = rvdec_pkg::CLS_SRL;
                    3'd6:    cls = rvdec_pkg::CLS_OR;
                    default: cls = rvdec_pkg::CLS_AND;
                endcase
                if (f3 == 3'd0 && alt) begin
                    cls = rvdec_pkg::CLS_SUB;
                    alu = rvdec_pkg::ALU_SUB;
                end
                if (f3 == 3'd5 && alt) begin
                    cls = rvdec_pkg::CLS_SRA;
                    alu = rvdec_pkg::ALU_SRA;
                end
            end
            rvdec_pkg::OPC_OPIMM: begin
                fmt  = rvdec_pkg::FMT_I;
                unit = rvdec_pkg::UNIT_ALU_I;
                alu  = alu_f3;
                case (f3)
                    3'd0:    cls = rvdec_pkg::CLS_ADDI;
                    3'd1:    cls = rvdec_pkg::CLS_SLLI;
                    3'd2:    cls = rvdec_pkg::CLS_SLTI;
                    3'd3:    cls = rvdec_pkg::CLS_SLTIU;
                    3'd4:    cls = rvdec_pkg::CLS_XORI;
                    3'd5:    cls = rvdec_pkg::CLS_SRLI;
                    3'd6:    cls = rvdec_pkg::CLS_ORI;
                    default: cls = rvdec_pkg::CLS_ANDI;
                endcase
                if (f3 == 3'd5 && alt) begin
                    cls = rvdec_pkg::CLS_SRAI;
                    alu = rvdec_pkg::ALU_SRA;
                end
            end
            rvdec_pkg::OPC_LOAD: begin
                fmt  = rvdec_pkg::FMT_I;
                unit = rvdec_pkg::UNIT_LOAD;
                case (f3)
                    3'd0:    cls = rvdec_pkg::CLS_LB;
                    3'd1:    cls = rvdec_pkg::CLS_LH;
                    3'd2:    cls = rvdec_pkg::CLS_LW;
                    3'd4:    cls = rvdec_pkg::CLS_LBU;
                    3'd5:    cls = rvdec_pkg::CLS_LHU;
                    default: cls = rvdec_pkg::CLS_UNKNOWN;
                endcase
            end
            rvdec_pkg::OPC_JALR: begin
                fmt  = rvdec_pkg::FMT_I;
                unit = rvdec_pkg::UNIT_JALR;
                cls  = rvdec_pkg::CLS_JALR;
            end
            rvdec_pkg::OPC_STORE: begin
                fmt  = rvdec_pkg::FMT_S;
                unit = rvdec_pkg::UNIT_STORE;
                case (f3)
                    3'd0:    cls = rvdec_pkg::CLS_SB;
                    3'd1:    cls = rvdec_pkg::CLS_SH;
                    3'd2:    cls = rvdec_pkg::CLS_SW;
                    default: cls = rvdec_pkg::CLS_UNKNOWN;
                endcase
            end
            rvdec_pkg::OPC_BRANCH: begin
                fmt  = rvdec_pkg::FMT_B;
                unit = rvdec_pkg::UNIT_BRANCH;
                alu  = rvdec_pkg::ALU_SUB;
                case (f3)
                    3'd0:    cls = rvdec_pkg::CLS_BEQ;
                    3'd1:    cls = rvdec_pkg::CLS_BNE;
                    3'd4:    cls = rvdec_pkg::CLS_BLT;
                    3'd5:    cls = rvdec_pkg::CLS_BGE;
                    3'd6:    cls = rvdec_pkg::CLS_BLTU;
                    3'd7:    cls = rvdec_pkg::CLS_BGEU;
                    default: cls = rvdec_pkg::CLS_UNKNOWN;
                endcase
            end
            rvdec_pkg::OPC_LUI: begin
                fmt = rvdec_pkg::FMT_U;
                cls = rvdec_pkg::CLS_LUI;
                alu = rvdec_pkg::ALU_PASS_IMM;
            end
            rvdec_pkg::OPC_AUIPC: begin
                fmt = rvdec_pkg::FMT_U;
                cls = rvdec_pkg::CLS_AUIPC;
                alu = rvdec_pkg::ALU_PC_PLUS;
            end
            rvdec_pkg::OPC_JAL: begin
                fmt  = rvdec_pkg::FMT_J;
                unit = rvdec_pkg::UNIT_JAL;
                cls  = rvdec_pkg::CLS_JAL;
            end
            rvdec_pkg::OPC_SYSTEM: begin
                unit = rvdec_pkg::UNIT_SYSTEM;
                // The rd and rs1 fields are not checked for these.
                if (f3 == 3'd0) begin
                    case (instruction[31:20])
                        rvdec_pkg::SYS_ENV_CALL:    cls = rvdec_pkg::CLS_ECALL;
                        rvdec_pkg::SYS_ENV_BREAK:   cls = rvdec_pkg::CLS_EBREAK;
                        rvdec_pkg::SYS_MACHINE_RET: cls = rvdec_pkg::CLS_MRET;
                        default:                    cls = rvdec_pkg::CLS_UNKNOWN;
                    endcase
                end
            end
            default: begin
                fmt = rvdec_pkg::FMT_R;
            end
        endcase
    end

    always_comb begin
        case (fmt)
            rvdec_pkg::FMT_I: imm = {{20{instruction[31]}}, instruction[31:20]};
            rvdec_pkg::FMT_S: imm = {{20{instruction[31]}}, instruction[31:25],
                                     instruction[11:7]};
            rvdec_pkg::FMT_B: imm = {{19{instruction[31]}}, instruction[31], instruction[7],
                                     instruction[30:25], instruction[11:8], 1'b0};
            rvdec_pkg::FMT_U: imm = {instruction[31:12], 12'h000};
            rvdec_pkg::FMT_J: imm = {{11{instruction[31]}}, instruction[31],
                                     instruction[19:12], instruction[20],
                                     instruction[30:21], 1'b0};
            default:          imm = 32'h0000_0000;
        endcase
    end

    always_comb begin
        result.dest_reg    = instruction[11:7];
        result.src1_reg    = instruction[19:15];
        result.src2_reg    = instruction[24:20];
        result.func3_field = f3;
        result.immediate   = $signed(imm);
        result.format_kind = fmt;
        result.instr_class = cls;
        result.alu_code    = alu;
        result.unit_kind   = unit;
        result.writes_dest = (opc != rvdec_pkg::OPC_BRANCH) && (opc != rvdec_pkg::OPC_STORE)
                             && (opc != rvdec_pkg::OPC_SYSTEM);
        result.reads_src1  = (fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_I)
                             || (fmt == rvdec_pkg::FMT_S) || (fmt == rvdec_pkg::FMT_B);
        result.reads_src2  = (fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_S)
                             || (fmt == rvdec_pkg::FMT_B);
    end

endmodule

`default_nettype wire

// ===== rtl/rvdec_out_reg.sv =====
`default_nettype none

module rvdec_out_reg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rvdec_pkg::decode_result_t  s_result,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rvdec_pkg::decode_result_t       m_result
);

    logic                      valid_reg;
    logic                      valid_next;
    rvdec_pkg::decode_result_t result_reg;

    // A waiting result blocks this stage; the input stage then takes a word only while it is empty.
    assign s_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            result_reg <= s_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/rv32i_instruction_decoder.sv =====
`default_nettype none

// Channel   Direction  tdata bits  Contents
// s_axis    in         32          instruction
// m_axis    out        72          decoded fields, two zero pad bits on top
//
// An instruction passes an input register and a result register: its result
// is offered on m_axis from the result register, and one instruction is
// taken every cycle while the result side keeps up.
// Reset clears both stage valid flags; no result is pending afterwards.
// When m_axis_tready is low the result register holds, and an empty input
// register still takes one more instruction before s_axis_tready falls.

module rv32i_instruction_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] instruction
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] dest_reg, [9:5] src1_reg, [14:10] src2_reg, [17:15] func3_field,
    // [49:18] immediate, [52:50] format_kind, [58:53] instr_class,
    // [62:59] alu_code, [66:63] unit_kind, [67] writes_dest, [68] reads_src1,
    // [69] reads_src2, [71:70] zero
    output logic [71:0]      m_axis_tdata
);

    logic                             word_valid;
    logic                             word_ready;
    logic [rvdec_pkg::InstrWidth-1:0] word;
    rvdec_pkg::decode_result_t        decoded;
    rvdec_pkg::decode_result_t        result;

    rvdec_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_word  (s_axis_tdata),
        .m_valid (word_valid),
        .m_ready (word_ready),
        .m_word  (word)
    );

    rvdec_decode u_decode (
        .instruction (word),
        .result      (decoded)
    );

    rvdec_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (word_valid),
        .s_ready  (word_ready),
        .s_result (decoded),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (result)
    );

    assign m_axis_tdata = {{rvdec_pkg::ResultPad{1'b0}}, result};

endmodule

`default_nettype wire
